// ===== src/hidkb_pkg.sv =====
// shared constants, key usage codes and the usage-to-ascii mapping
package hidkb_pkg;

  // line store geometry
  localparam int LineLength = 64;
  localparam int AddrW      = $clog2(LineLength);
  localparam int CharW      = 7;
  localparam int NumKeys    = 6;
  localparam int SlotW      = $clog2(NumKeys);

  // operation codes
  localparam logic [1:0] OpReport = 2'd0;
  localparam logic [1:0] OpClear  = 2'd1;
  localparam logic [1:0] OpRead   = 2'd2;

  // line phase codes
  localparam logic [1:0] PhaseIdle    = 2'd0;
  localparam logic [1:0] PhaseCollect = 2'd1;
  localparam logic [1:0] PhaseEnd     = 2'd2;

  // modifier and usage codes
  localparam logic [7:0] ShiftMask  = 8'h22;
  localparam logic [7:0] KeyNone    = 8'h00;
  localparam logic [7:0] KeyEnter   = 8'h28;
  localparam logic [7:0] KeyA       = 8'h04;
  localparam logic [7:0] KeyZ       = 8'h1D;
  localparam logic [7:0] KeyOne     = 8'h1E;
  localparam logic [7:0] KeyNine    = 8'h26;
  localparam logic [7:0] KeyZero    = 8'h27;
  localparam logic [7:0] KeySpace   = 8'h2C;
  localparam logic [7:0] KeyBslash  = 8'h31;
  localparam logic [7:0] KeySemi    = 8'h33;
  localparam logic [7:0] KeySlash   = 8'h38;

  typedef logic [CharW-1:0] char_t;

  // shifted digit row and the two punctuation groups
  localparam char_t ShiftDigits [9] = '{
    7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28
  };
  localparam char_t PunctA   [6] = '{7'h20, 7'h2D, 7'h3D, 7'h5B, 7'h5D, 7'h5C};
  localparam char_t PunctASh [6] = '{7'h20, 7'h5F, 7'h2B, 7'h7B, 7'h7D, 7'h7C};
  localparam char_t PunctB   [6] = '{7'h3B, 7'h27, 7'h60, 7'h2C, 7'h2E, 7'h2F};
  localparam char_t PunctBSh [6] = '{7'h3A, 7'h22, 7'h7E, 7'h3C, 7'h3E, 7'h3F};

  // ascii for a usage code, zero when the code gives no character
  function automatic char_t map_key(input logic [7:0] k, input logic sh);
    logic [7:0] off;
    char_t      c;
    c   = '0;
    off = '0;
    if (k >= KeyA && k <= KeyZ) begin
      off = k - KeyA;
      c   = CharW'(off) + (sh ? 7'h41 : 7'h61);
    end else if (k == KeyZero) begin
      c = sh ? 7'h29 : 7'h30;
    end else if (k >= KeyOne && k <= KeyNine) begin
      off = k - KeyOne;
      c   = sh ? ShiftDigits[off[3:0]] : CharW'(off) + 7'h31;
    end else if (k >= KeySpace && k <= KeyBslash) begin
      off = k - KeySpace;
      c   = sh ? PunctASh[off[2:0]] : PunctA[off[2:0]];
    end else if (k >= KeySemi && k <= KeySlash) begin
      off = k - KeySemi;
      c   = sh ? PunctBSh[off[2:0]] : PunctB[off[2:0]];
    end
    return c;
  endfunction

endpackage

// ===== src/hidkb_line_store.sv =====
// line store memory with per-entry valid bits so unwritten entries read as zero
module hidkb_line_store (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   we_i,
  input  logic [hidkb_pkg::AddrW-1:0] waddr_i,
  input  hidkb_pkg::char_t       wdata_i,
  input  logic [hidkb_pkg::AddrW-1:0] raddr_i,
  output hidkb_pkg::char_t       rdata_o
);
  import hidkb_pkg::*;

  char_t                 mem_q [LineLength];
  logic [LineLength-1:0] valid_q;
  char_t                 rdata_q;
  logic                  rvalid_q;

  // storage write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  // valid bits stand in for the all-zero reset contents
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

// ===== src/hid_keyboard_line_assembler.sv =====
// top level: hid keyboard report to ascii line assembler
//
// one request is taken at a rising edge with start high and busy low; the
// payload is the operation, the modifier byte, six key usage codes and a
// read index. each request gives exactly one result, held on line_state_o,
// char_count_o and read_char_o for the single cycle that done_o is high.
// the receiver cannot stall, so results are never held back.
// path from the accepting edge to done_o:
//   clear, unused operation, ignored report: done_o follows in the next cycle
//   read: through the SRead state, which takes the registered line store read
//   active report: through the SWalk state, one key slot per cycle (up to 6,
//   fewer when enter is seen), then done_o is registered as the walk ends
// the key walk writes at most one character a cycle into the line
// store; that walk sets the rate, and busy stays high while it runs.
// a new request may be accepted in the cycle where done_o is high.
// scan_enabled is written through cfg_we_i / cfg_wdata_i and resets to 1.
// reset puts the line in idle with a zero count and clears the valid bits
// of the line store, so every entry reads zero until written.
module hid_keyboard_line_assembler (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] operation_i,
  input  logic [7:0] modifiers_i,
  input  logic [7:0] key_0_i,
  input  logic [7:0] key_1_i,
  input  logic [7:0] key_2_i,
  input  logic [7:0] key_3_i,
  input  logic [7:0] key_4_i,
  input  logic [7:0] key_5_i,
  input  logic [5:0] read_index_i,
  output logic       done_o,
  output logic [1:0] line_state_o,
  output logic [5:0] char_count_o,
  output logic [6:0] read_char_o
);
  import hidkb_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SWalk = 2'd1;
  localparam logic [1:0] SRead = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [1:0]       phase_q, phase_d;
  logic [AddrW-1:0] count_q, count_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic             scan_en_q;
  logic             done_q, done_d;
  char_t            rchar_q, rchar_d;
  logic             inrange_q;
  logic [7:0]       key_q [NumKeys];
  logic             shift_q;

  logic             accept;
  logic [7:0]       cur_key;
  char_t            cur_char;
  logic             is_enter;
  logic             is_char;
  logic [AddrW-1:0] base_cnt;
  logic [AddrW-1:0] wr_addr;
  logic             mem_we;
  char_t            mem_rdata;

  assign accept  = start && !busy;
  assign busy    = (state_q != SIdle);

  // key of the current slot and its mapping
  assign cur_key  = key_q[slot_q];
  assign cur_char = map_key(cur_key, shift_q);
  assign is_enter = (cur_key == KeyEnter);
  assign is_char  = (cur_key != KeyNone) && !is_enter && (cur_char != '0);

  // first character of a line restarts the count, a full store wraps
  assign base_cnt = (phase_q != PhaseCollect) ? '0 : count_q;
  assign wr_addr  = (base_cnt == AddrW'(LineLength - 1)) ? '0 : base_cnt;
  assign mem_we   = (state_q == SWalk) && is_char;

  hidkb_line_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (wr_addr),
    .wdata_i (cur_char),
    .raddr_i (AddrW'(read_index_i)),
    .rdata_o (mem_rdata)
  );

  // request sequencer
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    count_d = count_q;
    slot_d  = slot_q;
    done_d  = 1'b0;
    rchar_d = '0;
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          priority if (operation_i == OpReport) begin
            if (scan_en_q && phase_q != PhaseEnd) begin
              state_d = SWalk;
              slot_d  = '0;
            end else begin
              done_d = 1'b1;
            end
          end else if (operation_i == OpClear) begin
            phase_d = PhaseIdle;
            count_d = '0;
            done_d  = 1'b1;
          end else if (operation_i == OpRead) begin
            state_d = SRead;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      SWalk: begin
        if (is_enter) begin
          if (count_q != '0) begin
            phase_d = PhaseEnd;
          end
        end else if (is_char) begin
          phase_d = PhaseCollect;
          count_d = wr_addr + AddrW'(1);
        end
        if (is_enter || slot_q == SlotW'(NumKeys - 1)) begin
          state_d = SIdle;
          done_d  = 1'b1;
        end else begin
          slot_d = slot_q + SlotW'(1);
        end
      end
      SRead: begin
        state_d = SIdle;
        done_d  = 1'b1;
        rchar_d = inrange_q ? mem_rdata : '0;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      phase_q   <= PhaseIdle;
      count_q   <= '0;
      slot_q    <= '0;
      done_q    <= 1'b0;
      scan_en_q <= 1'b1;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      count_q <= count_d;
      slot_q  <= slot_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        scan_en_q <= cfg_wdata_i;
      end
    end
  end

  // payload captured with the request
  always_ff @(posedge clk_i) begin
    rchar_q <= rchar_d;
    if (accept) begin
      key_q[0]  <= key_0_i;
      key_q[1]  <= key_1_i;
      key_q[2]  <= key_2_i;
      key_q[3]  <= key_3_i;
      key_q[4]  <= key_4_i;
      key_q[5]  <= key_5_i;
      shift_q   <= (modifiers_i & ShiftMask) != 8'h00;
      inrange_q <= (32'(read_index_i) < LineLength);
    end
  end

  // result ports
  assign done_o       = done_q;
  assign line_state_o = phase_q;
  assign char_count_o = 6'(count_q);
  assign read_char_o  = rchar_q;

  // checks
  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start && !busy) || $past(state_q != SIdle)))
    else $error("result strobe without a request in flight");

  a_idle_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && line_state_o == PhaseIdle) |-> (char_count_o == '0))
    else $error("idle line with a nonzero count");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SWalk) |-> (slot_q < SlotW'(NumKeys)))
    else $error("key slot out of range");

  a_char_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && read_char_o != '0) |-> $past(state_q == SRead))
    else $error("character returned for a request that is not a read");

endmodule

// ===== tb/sv/hid_keyboard_line_assembler_tb.sv =====
// testbench for the hid keyboard line assembler: directed and random requests against a line model
`timescale 1ns / 1ps

module hid_keyboard_line_assembler_tb;
  import hidkb_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 8;

  // printable rows, leftmost character is index 0
  localparam logic [8*9-1:0] DigitRowSh = "!@#$%^&*(";
  localparam logic [8*6-1:0] GroupA     = " -=[]\\";
  localparam logic [8*6-1:0] GroupASh   = " _+{}|";
  localparam logic [8*6-1:0] GroupB     = ";'`,./";
  localparam logic [8*6-1:0] GroupBSh   = ":\"~<>?";

  typedef struct packed {
    logic [1:0]      op;
    logic [7:0]      mods;
    logic [5:0][7:0] keys;
    logic [5:0]      idx;
  } key_request_t;

  typedef struct packed {
    logic [1:0] state;
    logic [5:0] count;
    logic [6:0] ch;
  } line_result_t;

  logic       clk_i;
  logic       rst_ni       = 1'b0;
  logic       cfg_we_i     = 1'b0;
  logic       cfg_wdata_i  = 1'b0;
  logic       start        = 1'b0;
  logic       busy;
  logic [1:0] operation_i  = '0;
  logic [7:0] modifiers_i  = '0;
  logic [7:0] key_0_i      = '0;
  logic [7:0] key_1_i      = '0;
  logic [7:0] key_2_i      = '0;
  logic [7:0] key_3_i      = '0;
  logic [7:0] key_4_i      = '0;
  logic [7:0] key_5_i      = '0;
  logic [5:0] read_index_i = '0;
  logic       done_o;
  logic [1:0] line_state_o;
  logic [5:0] char_count_o;
  logic [6:0] read_char_o;

  // line model state
  logic       scan_on = 1'b1;
  logic [1:0] line_phase = PhaseIdle;
  int         line_count = 0;
  logic [6:0] line_chars [LineLength] = '{default: '0};

  line_result_t pending_results [$];
  line_result_t due_result;
  int           fail_count = 0;
  int           cycles = 0;
  int           gap_max = 3;

  hid_keyboard_line_assembler dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation_i),
    .modifiers_i  (modifiers_i),
    .key_0_i      (key_0_i),
    .key_1_i      (key_1_i),
    .key_2_i      (key_2_i),
    .key_3_i      (key_3_i),
    .key_4_i      (key_4_i),
    .key_5_i      (key_5_i),
    .read_index_i (read_index_i),
    .done_o       (done_o),
    .line_state_o (line_state_o),
    .char_count_o (char_count_o),
    .read_char_o  (read_char_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ascii for a usage code, zero when nothing is typed
  function automatic logic [6:0] usage_to_ascii(input logic [7:0] code, input logic shifted);
    logic [7:0] ch;
    int off;
    ch = 8'h00;
    if (code >= KeyA && code <= KeyZ) begin
      off = int'(code - KeyA);
      ch  = 8'(off + (shifted ? 65 : 97));
    end else if (code == KeyZero) begin
      ch = shifted ? 8'h29 : 8'h30;
    end else if (code >= KeyOne && code <= KeyNine) begin
      off = int'(code - KeyOne);
      ch  = shifted ? DigitRowSh[8*(8-off) +: 8] : 8'(off + 49);
    end else if (code >= KeySpace && code <= KeyBslash) begin
      off = int'(code - KeySpace);
      ch  = shifted ? GroupASh[8*(5-off) +: 8] : GroupA[8*(5-off) +: 8];
    end else if (code >= KeySemi && code <= KeySlash) begin
      off = int'(code - KeySemi);
      ch  = shifted ? GroupBSh[8*(5-off) +: 8] : GroupB[8*(5-off) +: 8];
    end
    return ch[6:0];
  endfunction

  // advance the line model by one request and give the result it produces
  function automatic line_result_t assemble_line(input key_request_t r);
    line_result_t res;
    logic       shifted;
    logic       walking;
    logic [6:0] ch;
    res.ch = '0;
    if (r.op == OpReport) begin
      if (scan_on && line_phase != PhaseEnd) begin
        shifted = (r.mods & ShiftMask) != 8'h00;
        walking = 1'b1;
        for (int slot = 0; slot < 6; slot++) begin
          if (walking && r.keys[slot] != KeyNone) begin
            if (r.keys[slot] == KeyEnter) begin
              if (line_count != 0) line_phase = PhaseEnd;
              walking = 1'b0;
            end else begin
              ch = usage_to_ascii(r.keys[slot], shifted);
              if (ch != 7'h00) begin
                if (line_phase != PhaseCollect) line_count = 0;
                line_phase = PhaseCollect;
                if (line_count + 1 >= LineLength) line_count = 0;
                line_chars[line_count] = ch;
                line_count++;
              end
            end
          end
        end
      end
    end else if (r.op == OpClear) begin
      line_count = 0;
      line_phase = PhaseIdle;
    end else if (r.op == OpRead) begin
      res.ch = line_chars[r.idx];
    end
    res.state = line_phase;
    res.count = 6'(line_count);
    return res;
  endfunction

  function automatic key_request_t make_report(input logic [7:0] mods, input logic [7:0] k0,
                                                input logic [7:0] k1, input logic [7:0] k2,
                                                input logic [7:0] k3, input logic [7:0] k4,
                                                input logic [7:0] k5);
    key_request_t r;
    r.op   = OpReport;
    r.mods = mods;
    r.keys = {k5, k4, k3, k2, k1, k0};
    r.idx  = 6'($urandom);
    return r;
  endfunction

  // non-report request with random filler in the unused fields
  function automatic key_request_t make_cmd(input logic [1:0] op, input logic [5:0] idx);
    key_request_t r;
    r.op   = op;
    r.mods = 8'($urandom);
    r.keys = {16'($urandom), 32'($urandom)};
    r.idx  = idx;
    return r;
  endfunction

  function automatic logic [7:0] printable_key();
    case ($urandom_range(3))
      0:       return KeyA + 8'($urandom_range(25));
      1:       return KeyOne + 8'($urandom_range(9));
      2:       return KeySpace + 8'($urandom_range(5));
      default: return KeySemi + 8'($urandom_range(5));
    endcase
  endfunction

  function automatic logic [7:0] random_key(input int enter_pct);
    int p;
    p = $urandom_range(99);
    if (p < enter_pct) return KeyEnter;
    if (p < enter_pct + 12) return KeyNone;
    if (p < enter_pct + 20) return 8'($urandom);
    return printable_key();
  endfunction

  function automatic logic [7:0] random_mods();
    case ($urandom_range(4))
      0:       return 8'h00;
      1:       return 8'h02;
      2:       return 8'h20;
      3:       return ShiftMask;
      default: return 8'($urandom);
    endcase
  endfunction

  // drive one request and hold it until the block takes it
  task automatic send_request(input key_request_t r);
    int gap;
    gap = $urandom_range(gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    operation_i  <= r.op;
    modifiers_i  <= r.mods;
    key_0_i      <= r.keys[0];
    key_1_i      <= r.keys[1];
    key_2_i      <= r.keys[2];
    key_3_i      <= r.keys[3];
    key_4_i      <= r.keys[4];
    key_5_i      <= r.keys[5];
    read_index_i <= r.idx;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(assemble_line(r));
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_scan(input logic enable);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= enable;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    scan_on = enable;
  endtask

  // key ranges, shift, enter handling, clear, read and the unused operation
  task automatic test_directed();
    send_request(make_cmd(OpRead, 6'd0));
    send_request(make_cmd(OpRead, 6'd63));
    send_request(make_report(8'h00, KeyA, KeyZ, KeyOne, KeyNine, KeyZero, KeySpace));
    send_request(make_report(8'h02, KeyA, KeyZ, KeyOne, KeyNine, KeyZero, KeySpace));
    send_request(make_report(8'h20, KeyBslash, KeySemi, KeySlash, KeyNone, 8'h01, 8'hFF));
    send_request(make_report(8'hDD, KeyBslash, KeySemi, KeySlash, 8'h29, 8'h32, 8'h39));
    // enter ends the line, the keys after it are dropped
    send_request(make_report(8'hFF, KeyA + 8'd1, KeyEnter, KeyA, KeyA, KeyA, KeyA));
    send_request(make_report(8'h00, KeyA, KeyA + 8'd2, KeyNone, KeyNone, KeyNone, KeyNone));
    send_request(make_cmd(OpRead, 6'd2));
    send_request(make_cmd(2'd3, 6'($urandom)));
    send_request(make_cmd(OpClear, 6'($urandom)));
    // enter on an empty line changes nothing
    send_request(make_report(8'h00, KeyEnter, KeyA, KeyA, KeyA, KeyA, KeyA));
    // fill past the end of the store so the count wraps
    for (int i = 0; i < 13; i++) begin
      send_request(make_report(random_mods(), printable_key(), printable_key(), printable_key(),
                               printable_key(), printable_key(), printable_key()));
    end
    send_request(make_cmd(OpRead, 6'd62));
  endtask

  // reports ignored while scanning is off, clear still works
  task automatic test_scan_disable();
    send_request(make_report(8'h00, KeyA, KeyNone, KeyNone, KeyNone, KeyNone, KeyNone));
    write_scan(1'b0);
    send_request(make_report(8'h22, KeyA, KeyZ, KeyEnter, KeyNone, KeyNone, KeyNone));
    send_request(make_report(8'h00, KeyEnter, KeyNone, KeyNone, KeyNone, KeyNone, KeyNone));
    send_request(make_cmd(OpClear, 6'($urandom)));
    send_request(make_report(8'h00, KeyOne, KeyNone, KeyNone, KeyNone, KeyNone, KeyNone));
    send_request(make_cmd(OpRead, 6'd0));
    write_scan(1'b1);
    send_request(make_report(8'h02, KeyOne, KeyNone, KeyNone, KeyNone, KeyNone, KeyNone));
  endtask

  // typed lines with random content, reads, clears and noise
  task automatic test_random_lines();
    int enter_pct;
    int p;
    enter_pct = 3;
    for (int n = 0; n < 550; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(2))
          0:       enter_pct = 0;
          1:       enter_pct = 3;
          default: enter_pct = 10;
        endcase
        gap_max = ($urandom_range(2) == 0) ? 0 : 3;
      end
      if (n % 137 == 136) write_scan($urandom_range(3) != 0);
      p = $urandom_range(99);
      if (line_phase == PhaseEnd && p < 40) begin
        send_request(make_cmd(OpClear, 6'($urandom)));
      end else if (p < 65) begin
        send_request(make_report(random_mods(), random_key(enter_pct), random_key(enter_pct),
                                 random_key(enter_pct), random_key(enter_pct),
                                 random_key(enter_pct), random_key(enter_pct)));
      end else if (p < 73) begin
        send_request(make_cmd(OpClear, 6'($urandom)));
      end else if (p < 95) begin
        send_request(make_cmd(OpRead, 6'($urandom)));
      end else begin
        send_request(make_cmd(2'd3, 6'($urandom)));
      end
    end
  endtask

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        due_result = pending_results.pop_front();
        if (line_state_o !== due_result.state) begin
          $error("line_state expected %0d actual %0d", due_result.state, line_state_o);
          fail_count++;
        end
        if (char_count_o !== due_result.count) begin
          $error("char_count expected %0d actual %0d", due_result.count, char_count_o);
          fail_count++;
        end
        if (read_char_o !== due_result.ch) begin
          $error("read_char expected 0x%0h actual 0x%0h", due_result.ch, read_char_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_scan_disable();
    test_random_lines();
    drain_results();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
